@@ rtl/xxhash32_stream_defines.svh @@
// assertion macros for the checker file
`ifndef XXHASH32_STREAM_DEFINES_SVH
`define XXHASH32_STREAM_DEFINES_SVH

// same-cycle implication, reset masks the check
`define XXH_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("xxh32 check failed");

// next-cycle implication, reset masks the check
`define XXH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("xxh32 check failed");

`endif

@@ rtl/xxh32_pkg.sv @@
package xxh32_pkg;

  localparam logic [31:0] PRIME1 = 32'd2654435761;
  localparam logic [31:0] PRIME2 = 32'd2246822519;
  localparam logic [31:0] PRIME3 = 32'd3266489917;
  localparam logic [31:0] PRIME4 = 32'd668265263;
  localparam logic [31:0] PRIME5 = 32'd374761393;
  // lane seeds: PRIME1 + PRIME2 and -PRIME1, both mod 2^32
  localparam logic [31:0] LANE0_OFS = 32'd606290984;
  localparam logic [31:0] LANE3_OFS = 32'd1640531535;

  localparam int unsigned PADDR_W  = 3;
  localparam logic        REG_SEED = 1'b0;

  localparam int unsigned TDATA_IN_W = 40;
  localparam logic [2:0]  FULL_WORD  = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_LANE_A,
    ST_LANE_B,
    ST_INIT,
    ST_MERGE,
    ST_LEN,
    ST_WORD_A,
    ST_WORD_B,
    ST_BYTE_A,
    ST_BYTE_B,
    ST_AV_A,
    ST_AV_B,
    ST_OUT
  } state_e;

  function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned r);
    return (x << r) | (x >> (32 - r));
  endfunction

endpackage

@@ rtl/xxhash32_stream.sv @@
// xxHash32 over a stream of little-endian 32-bit words. Each input beat carries one word
// in tdata[31:0], its valid byte count in tdata[34:32] (4 on every beat but the last; 0 on
// the last beat ends an empty message) and tlast on the final beat; the block returns one
// 32-bit hash per message on the master side. Every multiply goes through one 32x32
// multiplier under a small sequencer, one multiply per cycle, and the input is not ready
// while it works. A word that does not close a 16-byte stripe is only stored; one that closes
// a stripe runs ST_LANE_A and ST_LANE_B for each lane (after ST_LOAD, which sets the lanes from
// the seed, for the first stripe of a message). The last beat runs those lane states first if
// it closes a stripe, then ST_INIT, ST_MERGE if a stripe was absorbed, ST_LEN, ST_WORD_A/B per
// leftover word, ST_BYTE_A/B per leftover byte, ST_AV_A/B and ST_OUT. The next message may
// start while the hash waits to be taken; the following hash then holds the block busy until
// the earlier one is taken. The seed register sits at APB address 0.
module xxhash32_stream (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // apb configuration
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [xxh32_pkg::PADDR_W-1:0]        paddr,
  input  logic [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready,
  // input stream
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [xxh32_pkg::TDATA_IN_W-1:0]     s_axis_tdata,  // data_word[31:0], byte_count[34:32]
  input  logic                                 s_axis_tlast,
  // output stream
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [31:0]                          m_axis_tdata   // hash_value[31:0]
);
  import xxh32_pkg::*;

  state_e      state_q, state_d;
  logic [31:0] seed_q;
  logic [31:0] lane_q [4];
  logic [31:0] lane_d [4];
  logic [31:0] stripe_q [3];
  logic        stripe_we;
  logic [1:0]  pos_q, pos_d;
  logic [1:0]  idx_q, idx_d;
  logic [31:0] len_q, len_d;
  logic        seen_q, seen_d;
  logic        fin_q, fin_d;
  logic [2:0]  cnt_q, cnt_d;
  logic [31:0] w_q, w_d;
  logic [31:0] t_q, t_d;
  logic [31:0] h_q, h_d;
  logic [31:0] hash_q, hash_d;
  logic        ov_q, ov_d;

  logic        in_acc;
  logic [31:0] in_word;
  logic [2:0]  in_cnt;
  logic        take_in;
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_full;
  logic [31:0] mul_p;
  logic [31:0] stripe_rd;
  logic [31:0] lane_word;
  logic [7:0]  byte_rd;
  logic        word_end, byte_end, has_bytes, out_free;

  assign pready = 1'b1;
  assign prdata = (paddr[PADDR_W-1] == REG_SEED) ? seed_q : 32'd0;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign in_word = s_axis_tdata[31:0];
  assign in_cnt  = s_axis_tdata[34] ? FULL_WORD : s_axis_tdata[34:32];
  // a beat that fills a word: every non-last beat and a full last beat
  assign take_in = !s_axis_tlast || (in_cnt == FULL_WORD);

  assign mul_full = mul_a * mul_b;
  assign mul_p    = mul_full[31:0];

  always_comb begin
    case (idx_q)
      2'd0:    stripe_rd = stripe_q[0];
      2'd1:    stripe_rd = stripe_q[1];
      default: stripe_rd = stripe_q[2];
    endcase
    lane_word = (idx_q == 2'd3) ? w_q : stripe_rd;
    case (idx_q)
      2'd0:    byte_rd = w_q[7:0];
      2'd1:    byte_rd = w_q[15:8];
      2'd2:    byte_rd = w_q[23:16];
      default: byte_rd = w_q[31:24];
    endcase
  end

  assign word_end  = (idx_q == (pos_q - 2'd1));
  assign byte_end  = ({1'b0, idx_q} == (cnt_q - 3'd1));
  assign has_bytes = (cnt_q != 3'd0) && (cnt_q != FULL_WORD);
  assign out_free  = !ov_q || m_axis_tready;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (take_in && pos_q == 2'd3) begin
            state_d = seen_q ? ST_LANE_A : ST_LOAD;
          end else if (s_axis_tlast) begin
            state_d = ST_INIT;
          end
        end
      end
      ST_LOAD:   state_d = ST_LANE_A;
      ST_LANE_A: state_d = ST_LANE_B;
      ST_LANE_B: begin
        if (idx_q == 2'd3) begin
          state_d = fin_q ? ST_INIT : ST_IDLE;
        end else begin
          state_d = ST_LANE_A;
        end
      end
      ST_INIT:   state_d = seen_q ? ST_MERGE : ST_LEN;
      ST_MERGE:  state_d = ST_LEN;
      ST_LEN: begin
        if (pos_q != 2'd0) begin
          state_d = ST_WORD_A;
        end else begin
          state_d = has_bytes ? ST_BYTE_A : ST_AV_A;
        end
      end
      ST_WORD_A: state_d = ST_WORD_B;
      ST_WORD_B: begin
        if (word_end) begin
          state_d = has_bytes ? ST_BYTE_A : ST_AV_A;
        end else begin
          state_d = ST_WORD_A;
        end
      end
      ST_BYTE_A: state_d = ST_BYTE_B;
      ST_BYTE_B: state_d = byte_end ? ST_AV_A : ST_BYTE_A;
      ST_AV_A:   state_d = ST_AV_B;
      ST_AV_B:   state_d = ST_OUT;
      ST_OUT:    state_d = out_free ? ST_IDLE : ST_OUT;
      default:   state_d = ST_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    s_axis_tready = (state_q == ST_IDLE);
    lane_d    = lane_q;
    stripe_we = 1'b0;
    pos_d     = pos_q;
    idx_d     = idx_q;
    len_d     = len_q;
    seen_d    = seen_q;
    fin_d     = fin_q;
    cnt_d     = cnt_q;
    w_d       = w_q;
    t_d       = t_q;
    h_d       = h_q;
    hash_d    = hash_q;
    ov_d      = ov_q && !m_axis_tready;
    mul_a     = 32'd0;
    mul_b     = 32'd0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          w_d   = in_word;
          fin_d = s_axis_tlast;
          cnt_d = s_axis_tlast ? in_cnt : FULL_WORD;
          len_d = len_q + {29'd0, (s_axis_tlast ? in_cnt : FULL_WORD)};
          idx_d = 2'd0;
          if (take_in && pos_q != 2'd3) begin
            stripe_we = 1'b1;
            pos_d     = pos_q + 2'd1;
          end
        end
      end
      ST_LOAD: begin
        lane_d[0] = seed_q + LANE0_OFS;
        lane_d[1] = seed_q + PRIME2;
        lane_d[2] = seed_q;
        lane_d[3] = seed_q + LANE3_OFS;
        seen_d    = 1'b1;
      end
      ST_LANE_A: begin
        mul_a = lane_word;
        mul_b = PRIME2;
        t_d   = mul_p;
      end
      ST_LANE_B: begin
        mul_a         = rotl(lane_q[idx_q] + t_q, 13);
        mul_b         = PRIME1;
        lane_d[idx_q] = mul_p;
        idx_d         = idx_q + 2'd1;
        if (idx_q == 2'd3) begin
          pos_d = 2'd0;
        end
      end
      ST_INIT: begin
        h_d = seen_q ? (rotl(lane_q[0], 1) + rotl(lane_q[1], 7)) : (seed_q + PRIME5);
      end
      ST_MERGE: begin
        h_d = h_q + rotl(lane_q[2], 12) + rotl(lane_q[3], 18);
      end
      ST_LEN: begin
        h_d   = h_q + len_q;
        idx_d = 2'd0;
      end
      ST_WORD_A: begin
        mul_a = stripe_rd;
        mul_b = PRIME3;
        t_d   = mul_p;
      end
      ST_WORD_B: begin
        mul_a = rotl(h_q + t_q, 17);
        mul_b = PRIME4;
        h_d   = mul_p;
        idx_d = word_end ? 2'd0 : idx_q + 2'd1;
      end
      ST_BYTE_A: begin
        mul_a = {24'd0, byte_rd};
        mul_b = PRIME5;
        t_d   = mul_p;
      end
      ST_BYTE_B: begin
        mul_a = rotl(h_q + t_q, 11);
        mul_b = PRIME1;
        h_d   = mul_p;
        idx_d = idx_q + 2'd1;
      end
      ST_AV_A: begin
        mul_a = h_q ^ (h_q >> 15);
        mul_b = PRIME2;
        h_d   = mul_p;
      end
      ST_AV_B: begin
        mul_a = h_q ^ (h_q >> 13);
        mul_b = PRIME3;
        h_d   = mul_p;
      end
      ST_OUT: begin
        if (out_free) begin
          hash_d = h_q ^ (h_q >> 16);
          ov_d   = 1'b1;
          pos_d  = 2'd0;
          len_d  = 32'd0;
          seen_d = 1'b0;
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = hash_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      seed_q  <= 32'd0;
      pos_q   <= 2'd0;
      idx_q   <= 2'd0;
      len_q   <= 32'd0;
      seen_q  <= 1'b0;
      fin_q   <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      idx_q   <= idx_d;
      len_q   <= len_d;
      seen_q  <= seen_d;
      fin_q   <= fin_d;
      ov_q    <= ov_d;
      if (psel && penable && pwrite && paddr[PADDR_W-1] == REG_SEED) begin
        seed_q <= pwdata;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    lane_q <= lane_d;
    cnt_q  <= cnt_d;
    w_q    <= w_d;
    t_q    <= t_d;
    h_q    <= h_d;
    hash_q <= hash_d;
    if (stripe_we) begin
      stripe_q[pos_q] <= in_word;
    end
  end

endmodule

@@ rtl/xxh32_chk.sv @@
module xxh32_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        s_axis_tlast,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);
`include "xxhash32_stream_defines.svh"

  // a waiting hash beat holds still
  `XXH_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

  // a last beat always starts the finishing sequence
  `XXH_ASSERT_NEXT(a_last_busy, clk_i, rst_ni, s_axis_tvalid && s_axis_tready && s_axis_tlast, !s_axis_tready)

  // a fresh hash only comes out of the busy finishing sequence
  `XXH_ASSERT_NOW(a_out_after_busy, clk_i, rst_ni, $rose(m_axis_tvalid), !$past(s_axis_tready))

  // a beat that is not last never yields a hash straight away
  `XXH_ASSERT_NEXT(a_no_early_hash, clk_i, rst_ni, s_axis_tvalid && s_axis_tready && !s_axis_tlast, !$rose(m_axis_tvalid))

endmodule

bind xxhash32_stream xxh32_chk u_xxh32_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

@@ sim/tb_xxhash32_stream.sv @@
`timescale 1ns / 1ps

module tb_xxhash32_stream;
  import xxh32_pkg::*;

  localparam logic [PADDR_W-1:0] SEED_ADDR = PADDR_W'(4 * REG_SEED);
  localparam int unsigned SETTLE_CYCLES  = 40;
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned IDLE_PCT       = 25;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  nbytes;
    logic        fin;
  } beat_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [PADDR_W-1:0]    paddr = '0;
  logic [31:0]           pwdata = '0;
  logic [31:0]           prdata;
  logic                  pready;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [TDATA_IN_W-1:0] s_axis_tdata = '0;  // data_word[31:0], byte_count[34:32]
  logic                  s_axis_tlast = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [31:0]           m_axis_tdata;       // hash_value[31:0]

  xxhash32_stream dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #10 clk_i = ~clk_i;

  beat_t       beat_q [$];
  logic [31:0] hash_q [$];
  bit          steady = 1'b0;
  int unsigned beats_queued = 0;
  int unsigned fail_count = 0;
  int unsigned quiet = 0;

  // shadow of the hash engine
  logic [31:0] seed_shadow = '0;
  logic [31:0] lane_acc [4];
  logic [31:0] held_word [3];
  int unsigned held_cnt = 0;
  logic [31:0] byte_total = '0;
  bit          lanes_loaded = 1'b0;

  function automatic logic [31:0] rol32(input logic [31:0] x, input int unsigned r);
    return (x << r) | (x >> (32 - r));
  endfunction

  function automatic logic [31:0] mix_lane(input logic [31:0] acc, input logic [31:0] w);
    logic [31:0] t;
    t = acc + w * PRIME2;
    return rol32(t, 13) * PRIME1;
  endfunction

  task automatic absorb_word(input logic [31:0] w);
    int i;
    if (held_cnt < 3) begin
      held_word[held_cnt] = w;
      held_cnt++;
    end else begin
      // lanes take the seed when the first stripe of a message closes
      if (!lanes_loaded) begin
        lane_acc[0] = seed_shadow + LANE0_OFS;
        lane_acc[1] = seed_shadow + PRIME2;
        lane_acc[2] = seed_shadow;
        lane_acc[3] = seed_shadow - PRIME1;
        lanes_loaded = 1'b1;
      end
      for (i = 0; i < 3; i++) lane_acc[i] = mix_lane(lane_acc[i], held_word[i]);
      lane_acc[3] = mix_lane(lane_acc[3], w);
      held_cnt = 0;
    end
  endtask

  task automatic predict_beat(input logic [31:0] w, input logic [2:0] cnt, input logic fin);
    logic [31:0] h;
    int unsigned n;
    int i;
    if (!fin) begin
      // byte count is ignored before the last beat
      absorb_word(w);
      byte_total += 4;
    end else begin
      n = (cnt > FULL_WORD) ? FULL_WORD : cnt;
      if (n == FULL_WORD) absorb_word(w);
      byte_total += n;
      if (lanes_loaded) begin
        h = rol32(lane_acc[0], 1) + rol32(lane_acc[1], 7) + rol32(lane_acc[2], 12)
          + rol32(lane_acc[3], 18);
      end else begin
        h = seed_shadow + PRIME5;
      end
      h += byte_total;
      for (i = 0; i < held_cnt; i++) begin
        h += held_word[i] * PRIME3;
        h = rol32(h, 17) * PRIME4;
      end
      if (n < FULL_WORD) begin
        for (i = 0; i < n; i++) begin
          h += ((w >> (8 * i)) & 32'hFF) * PRIME5;
          h = rol32(h, 11) * PRIME1;
        end
      end
      h ^= h >> 15;
      h = h * PRIME2;
      h ^= h >> 13;
      h = h * PRIME3;
      h ^= h >> 16;
      hash_q.push_back(h);
      held_cnt = 0;
      byte_total = '0;
      lanes_loaded = 1'b0;
    end
  endtask

  task automatic report_fault(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endtask

  // input driver
  always @(posedge clk_i) begin : drive_blk
    beat_t nxt;
    if (rst_ni) begin
      if (!s_axis_tvalid || s_axis_tready) begin
        if (beat_q.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
          nxt = beat_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {{(TDATA_IN_W - 35){1'b0}}, nxt.nbytes, nxt.word};
          s_axis_tlast  <= nxt.fin;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // monitor: seed writes, accepted input beats and returned hashes
  always @(posedge clk_i) begin : mon_blk
    logic [31:0] want;
    if (rst_ni) begin
      if (psel && penable && pwrite && pready && paddr == SEED_ADDR) seed_shadow = pwdata;
      if (s_axis_tvalid && s_axis_tready)
        predict_beat(s_axis_tdata[31:0], s_axis_tdata[34:32], s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) begin
        if (hash_q.size() == 0) begin
          report_fault($sformatf("unexpected hash %08h", m_axis_tdata));
        end else begin
          want = hash_q.pop_front();
          if (m_axis_tdata !== want)
            report_fault($sformatf("hash_value: expected %08h, got %08h", want, m_axis_tdata));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet <= 0;
    end else if (quiet >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic push_beat(input logic [31:0] w, input logic [2:0] cnt, input logic fin);
    beat_t b;
    b.word   = w;
    b.nbytes = cnt;
    b.fin    = fin;
    beat_q.push_back(b);
    beats_queued++;
  endtask

  // mostly well-formed messages; now and then a junk count on a non-last beat
  // or an oversized count on a closing full word
  task automatic queue_message(input int unsigned len);
    int unsigned full_words;
    int unsigned tail;
    int unsigned k;
    logic [2:0]  cnt;
    logic        fin;
    full_words = len / 4;
    tail = len % 4;
    for (k = 0; k < full_words; k++) begin
      fin = (tail == 0) && (k == full_words - 1);
      cnt = FULL_WORD;
      if (!fin && $urandom_range(9) == 0) cnt = 3'($urandom_range(7));
      if (fin && $urandom_range(7) == 0) cnt = 3'($urandom_range(7, 5));
      push_beat($urandom, cnt, fin);
    end
    if (tail != 0 || len == 0) push_beat($urandom, 3'(tail), 1'b1);
  endtask

  function automatic int unsigned pick_length();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 80) return $urandom_range(40);
    if (r < 95) return $urandom_range(100, 41);
    return $urandom_range(300, 101);
  endfunction

  task automatic write_seed(input logic [31:0] v);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= SEED_ADDR;
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic drain();
    do @(negedge clk_i);
    while (beat_q.size() != 0 || s_axis_tvalid || hash_q.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  initial begin : run_blk
    logic [31:0] seeds [5];
    int unsigned p;
    int unsigned k;
    int unsigned target;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed messages under the reset seed
    push_beat(32'h0000_0000, 3'd0, 1'b1);           // empty message
    push_beat(32'h0000_00A5, 3'd1, 1'b1);
    push_beat(32'hDEAD_BEEF, 3'd2, 1'b1);           // unused bytes set
    push_beat(32'hFFFF_FFFF, 3'd3, 1'b1);
    push_beat(32'hFFFF_FFFF, FULL_WORD, 1'b1);
    push_beat(32'h0123_4567, 3'd5, 1'b1);           // oversized counts saturate
    push_beat(32'h89AB_CDEF, 3'd7, 1'b1);
    push_beat(32'h0000_0000, 3'd0, 1'b0);           // short count before last
    push_beat(32'h1234_5678, 3'd6, 1'b1);
    push_beat(32'hFFFF_FFFF, FULL_WORD, 1'b0);      // exactly one stripe
    push_beat(32'hFFFF_FFFF, 3'd1, 1'b0);
    push_beat(32'hFFFF_FFFF, 3'd7, 1'b0);
    push_beat(32'h0000_0000, FULL_WORD, 1'b1);
    for (k = 0; k < 4; k++) push_beat($urandom, FULL_WORD, 1'b0);
    push_beat($urandom, 3'd3, 1'b1);                // stripe plus trailing bytes
    for (k = 0; k < 6; k++) push_beat($urandom, FULL_WORD, 1'b0);
    push_beat($urandom, FULL_WORD, 1'b1);           // stripe plus leftover words
    drain();

    seeds[0] = 32'hFFFF_FFFF;
    seeds[1] = 32'h0000_0000;
    seeds[2] = $urandom;
    seeds[3] = 32'h8000_0000;
    seeds[4] = $urandom;
    for (p = 0; p < 5; p++) begin
      write_seed(seeds[p]);
      steady = (p == 2);
      target = beats_queued + 120;
      while (beats_queued < target) queue_message(pick_length());
      drain();
    end

    if (fail_count == 0 && hash_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ xxhash32_stream.f @@
+incdir+rtl
rtl/xxh32_pkg.sv
rtl/xxhash32_stream.sv
rtl/xxh32_chk.sv
sim/tb_xxhash32_stream.sv
